>>> sv/dclg_pkg.sv
// ----------------------------------------------------------------------------
// dclg_pkg: shared types and constants of the duty-cycle / LBT gate
// Sub-band plan, ring entry layout, decision and config codes, FSM states.
// ----------------------------------------------------------------------------
package dclg_pkg;

  // Ring geometry (depth must be a power of two: index wraps naturally)
  localparam int HISTORY_SLOTS = 32;
  localparam int SLOT_IDX_W    = $clog2(HISTORY_SLOTS);
  localparam int SLOT_CNT_W    = SLOT_IDX_W + 1;

  // Field widths
  localparam int HZ_W    = 30;
  localparam int AIR_W   = 24;
  localparam int TIME_W  = 32;
  localparam int RSSI_W  = 9;
  localparam int BAND_W  = 3;
  localparam int WIN_W   = 22;
  localparam int CFG_W   = 22;
  localparam int CFG_IDX_W = 2;

  // Airtime sums: one bit of headroom over a full ring plus the request
  localparam int ACC_W   = AIR_W + SLOT_IDX_W + 1;

  // Budget: permille * window / 1000, the divide done as a reciprocal multiply
  localparam int PM_W        = 7;
  localparam int DIVIDEND_W  = WIN_W + PM_W;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 39;
  localparam int SCALED_W    = DIVIDEND_W + RECIP_W;
  // ceil(2^39 / 1000); exact for every dividend below 2^29
  localparam logic [RECIP_W-1:0] BUDGET_RECIP = 30'd549755814;

  // Sub-band edges, lower inclusive, upper exclusive
  localparam logic [HZ_W-1:0] BAND_LO [5] = '{
    30'd863000000, 30'd868000000, 30'd868700000, 30'd869400000, 30'd869700000
  };
  localparam logic [HZ_W-1:0] BAND_HI [5] = '{
    30'd868000000, 30'd868600000, 30'd869200000, 30'd869650000, 30'd870000000
  };
  // Permille per band code (code 0 = no band)
  localparam logic [PM_W-1:0] BAND_PM [8] = '{
    7'd0, 7'd10, 7'd10, 7'd1, 7'd100, 7'd10, 7'd0, 7'd0
  };

  localparam logic OP_EVAL   = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  localparam logic [BAND_W-1:0] BAND_NONE = '0;

  typedef enum logic [2:0] {
    DEC_ALLOW = 3'd0,
    DEC_SOS   = 3'd1,
    DEC_BLOCK = 3'd2,
    DEC_BUSY  = 3'd3,
    DEC_ERROR = 3'd4
  } decision_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_SOS    = 2'd1,
    CFG_BUSY   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  // One ring entry: 60 bits
  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [AIR_W-1:0]  air;
    logic [BAND_W-1:0] band;
    logic              sos;
  } ring_entry_t;

  // Budget unit handshake
  typedef struct packed {
    logic              start;
    logic [BAND_W-1:0] band;
  } bud_req_t;

  // Map a carrier to its sub-band code, 0 when outside all bands
  function automatic logic [BAND_W-1:0] find_band(logic [HZ_W-1:0] hz);
    logic [BAND_W-1:0] b;
    b = BAND_NONE;
    for (int i = 4; i >= 0; i--) begin
      if (hz >= BAND_LO[i] && hz < BAND_HI[i]) b = BAND_W'(i + 1);
    end
    return b;
  endfunction

endpackage

>>> sv/duty_cycle_lbt_gate_core.sv
// ----------------------------------------------------------------------------
// duty_cycle_lbt_gate_core: EU868 duty-cycle and listen-before-talk gate
//
// Input channel (in_valid_i/in_ready_o) takes one word per request. A record
// word (op = 1) logs a transmission in a 32-slot history ring, overwriting
// the oldest slot once full; it produces no output word and leaves the block
// idle, so the next word can follow right behind it. An evaluate word
// (op = 0) produces exactly one decision word on the output channel
// (out_valid_o/out_ready_i). A carrier outside every sub-band skips the walk
// and answers error. Otherwise the ring is walked one slot per cycle
// through the memory's single read port while the band budget is computed
// beside it in the budget unit; no further word is taken until the decision
// has moved to the output register. Only one evaluate is in flight.
// The output is registered: while the receiver stalls, the finished decision
// is held and record words are still taken; a later evaluate waits for the
// output register to free up before finishing.
// Reset empties the ring (fill and head cleared), restores the config
// registers to their defaults and drops any pending output. Ring contents
// are not cleared; slots past the fill count are never read.
// ----------------------------------------------------------------------------
module duty_cycle_lbt_gate_core import dclg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  // request channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic [HZ_W-1:0]          carrier_hz_i,
  input  logic [AIR_W-1:0]         air_ms_i,
  input  logic [TIME_W-1:0]        time_now_ms_i,
  input  logic                     sos_flag_i,
  input  logic signed [RSSI_W-1:0] channel_rssi_dbm_i,
  // decision channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               decision_o
);

  state_e state_q, state_d;

  // config registers
  logic [WIN_W-1:0]         window_q;
  logic [WIN_W-1:0]         sos_allow_q;
  logic signed [RSSI_W-1:0] busy_thr_q;

  // ring pointers
  logic [SLOT_IDX_W-1:0] head_q, head_d;
  logic [SLOT_CNT_W-1:0] fill_q, fill_d;
  logic [SLOT_CNT_W-1:0] cnt_q, cnt_d;
  logic                  rd_vld_q;

  // latched request
  logic [BAND_W-1:0]        band_q;
  logic [AIR_W-1:0]         air_q;
  logic [TIME_W-1:0]        now_q;
  logic                     sos_q;
  logic signed [RSSI_W-1:0] rssi_q;

  // sums and result
  logic [ACC_W-1:0] sum_all_q, sum_sos_q;
  decision_e        res_q, res_d;
  decision_e        out_dec_q;
  logic             out_valid_q, out_valid_d;

  logic                  in_acc, acc_eval, acc_rec;
  logic [BAND_W-1:0]     band_in;
  logic                  issue, walk_done, out_load;
  logic                  match;
  logic [TIME_W-1:0]     age;
  ring_entry_t           wentry, rentry;
  bud_req_t              bud_req;
  logic                  bud_done;
  logic [DIVIDEND_W-1:0] budget;
  logic [ACC_W-1:0]      need_all, need_sos;
  decision_e             dec_calc;

  assign band_in  = find_band(carrier_hz_i);
  assign in_acc   = in_valid_i && in_ready_o;
  assign acc_eval = in_acc && (op_i == OP_EVAL);
  assign acc_rec  = in_acc && (op_i == OP_RECORD);

  // config writes; unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WIN_W'(3600000);
      sos_allow_q <= WIN_W'(36000);
      busy_thr_q  <= -RSSI_W'(80);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW: window_q    <= cfg_wdata_i;
        CFG_SOS:    sos_allow_q <= cfg_wdata_i;
        CFG_BUSY:   busy_thr_q  <= cfg_wdata_i[RSSI_W-1:0];
        default:    ;
      endcase
    end
  end

  // history ring
  assign wentry = '{t: time_now_ms_i, air: air_ms_i, band: band_in, sos: sos_flag_i};

  dclg_ring_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (acc_rec),
    .waddr_i (head_q + fill_q[SLOT_IDX_W-1:0]),
    .wdata_i (wentry),
    .re_i    (issue),
    .raddr_i (head_q + cnt_q[SLOT_IDX_W-1:0]),
    .rdata_o (rentry)
  );

  // budget unit runs alongside the walk
  assign bud_req = '{start: acc_eval, band: band_in};

  dclg_budget u_bud (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (bud_req),
    .window_i (window_q),
    .done_o   (bud_done),
    .budget_o (budget)
  );

  // ring pointer update on record
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (acc_rec) begin
      if (fill_q == SLOT_CNT_W'(HISTORY_SLOTS)) head_d = head_q + SLOT_IDX_W'(1);
      else                                      fill_d = fill_q + SLOT_CNT_W'(1);
    end
  end

  // entry qualifies: same band, age within window (mod 2^32)
  assign age   = now_q - rentry.t;
  assign match = (rentry.band == band_q) && (age <= TIME_W'(window_q));

  // decision from final sums
  assign need_all = sum_all_q + ACC_W'(air_q);
  assign need_sos = sum_sos_q + ACC_W'(air_q);
  always_comb begin
    if (need_all <= ACC_W'(budget))                dec_calc = DEC_ALLOW;
    else if (sos_q && need_sos <= ACC_W'(sos_allow_q)) dec_calc = DEC_SOS;
    else                                           dec_calc = DEC_BLOCK;
    if (dec_calc != DEC_BLOCK && rssi_q >= busy_thr_q) dec_calc = DEC_BUSY;
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    issue      = (state_q == ST_WALK) && (cnt_q < fill_q);
    walk_done  = (state_q == ST_WALK) && !issue && !rd_vld_q && bud_done;
    out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
    cnt_d      = acc_eval ? '0 : (issue ? cnt_q + SLOT_CNT_W'(1) : cnt_q);
    res_d      = res_q;
    if (acc_eval && band_in == BAND_NONE) res_d = DEC_ERROR;
    else if (walk_done)                   res_d = dec_calc;
    out_valid_d = out_load ? 1'b1 : ((out_valid_q && out_ready_i) ? 1'b0 : out_valid_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc_eval) state_d = (band_in == BAND_NONE) ? ST_DONE : ST_WALK;
      ST_WALK: if (walk_done) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  // request latch, sums, result; datapath without reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (acc_eval) begin
      band_q    <= band_in;
      air_q     <= air_ms_i;
      now_q     <= time_now_ms_i;
      sos_q     <= sos_flag_i;
      rssi_q    <= channel_rssi_dbm_i;
      sum_all_q <= '0;
      sum_sos_q <= '0;
    end else if (rd_vld_q && match) begin
      sum_all_q <= sum_all_q + ACC_W'(rentry.air);
      if (rentry.sos) sum_sos_q <= sum_sos_q + ACC_W'(rentry.air);
    end
    if (out_load) out_dec_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign decision_o  = out_dec_q;

endmodule

>>> sv/dclg_ring_mem.sv
// ----------------------------------------------------------------------------
// dclg_ring_mem: transmission history storage
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module dclg_ring_mem import dclg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [SLOT_IDX_W-1:0] waddr_i,
  input  ring_entry_t           wdata_i,
  input  logic                  re_i,
  input  logic [SLOT_IDX_W-1:0] raddr_i,
  output ring_entry_t           rdata_o
);

  ring_entry_t mem_q [HISTORY_SLOTS];
  ring_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/dclg_budget.sv
// ----------------------------------------------------------------------------
// dclg_budget: per-band airtime budget
// permille * window registered in prod_q, then / 1000 by reciprocal multiply into quo_q.
// ----------------------------------------------------------------------------
module dclg_budget import dclg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bud_req_t              req_i,
  input  logic [WIN_W-1:0]      window_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] budget_o
);

  logic [DIVIDEND_W-1:0] prod_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic                  busy_q;
  logic [DIVIDEND_W-1:0] product;
  logic [SCALED_W-1:0]   scaled;

  // dividend: small constant-table multiply
  assign product = DIVIDEND_W'(window_i) * DIVIDEND_W'(BAND_PM[req_i.band]);

  // divide by 1000: scaled reciprocal, keep the bits above the shift
  assign scaled = SCALED_W'(prod_q) * SCALED_W'(BUDGET_RECIP);

  // second stage pending for one cycle after start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= req_i.start;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.start) prod_q <= product;
    if (busy_q)      quo_q  <= DIVIDEND_W'(scaled >> RECIP_SHIFT);
  end

  assign done_o   = !busy_q;
  assign budget_o = quo_q;

endmodule

>>> sv/dclg_checker.sv
// ----------------------------------------------------------------------------
// dclg_checker: port-level checks for the duty-cycle / LBT gate
// Watches handshakes and decision codes; bound to the top level.
// ----------------------------------------------------------------------------
module dclg_checker import dclg_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     op_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [2:0]               decision_o
);

  // stalled decision word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(decision_o))
    else $error("decision word changed while stalled");

  // only defined decision codes leave the block
  a_dec_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> decision_o <= 3'(DEC_ERROR))
    else $error("undefined decision code");

  // an accepted evaluate occupies the block: the input drops ready right after it
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_EVAL |=> !in_ready_o)
    else $error("evaluate did not occupy the block");

  // a record word leaves the input ready for the next word
  a_rec_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_RECORD |=> in_ready_o)
    else $error("record word stalled the input");

endmodule

bind duty_cycle_lbt_gate_core dclg_checker u_dclg_checker (.*);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for duty_cycle_lbt_gate_core
// Drives record and evaluate words through the request channel, predicts each
// decision from a local copy of the history ring and the config registers, and
// compares every decision word in order. The sender works in bursts with gaps,
// the receiver stalls on its own pattern, and the config is changed between
// phases once the block has gone quiet.
// ----------------------------------------------------------------------------
package gate_tb_pkg;
  import dclg_pkg::*;

  localparam int unsigned RING_DEPTH = 32;

  // EU868 sub-band plan: lower edge inclusive, upper edge exclusive
  localparam int unsigned SUBBAND_LO [5] = '{
    863000000, 868000000, 868700000, 869400000, 869700000
  };
  localparam int unsigned SUBBAND_HI [5] = '{
    868000000, 868600000, 869200000, 869650000, 870000000
  };
  // permille budget per band code, code 0 is no band
  localparam int unsigned SUBBAND_PM [8] = '{0, 10, 10, 1, 100, 10, 0, 0};

  // unused config index: writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  class gate_scoreboard;
    // config copy
    logic [31:0]              win_ms   = 32'd3600000;
    logic [31:0]              sos_ms   = 32'd36000;
    logic signed [RSSI_W-1:0] busy_dbm = -9'sd80;

    // history ring copy
    logic [TIME_W-1:0] ent_t    [RING_DEPTH];
    logic [AIR_W-1:0]  ent_air  [RING_DEPTH];
    logic [BAND_W-1:0] ent_band [RING_DEPTH];
    logic              ent_sos  [RING_DEPTH];
    int unsigned       head = 0;
    int unsigned       fill = 0;

    decision_e expected_decisions [$];
    int unsigned errors = 0;

    function automatic logic [BAND_W-1:0] subband_of(logic [HZ_W-1:0] hz);
      for (int i = 0; i < 5; i++) begin
        if (32'(hz) >= SUBBAND_LO[i] && 32'(hz) < SUBBAND_HI[i]) return BAND_W'(i + 1);
      end
      return BAND_NONE;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_WINDOW: win_ms = 32'(data);
        CFG_SOS:    sos_ms = 32'(data);
        CFG_BUSY:   busy_dbm = data[RSSI_W-1:0];
        default: ;
      endcase
    endfunction

    // Take one accepted request word; evaluate words queue their decision
    function void note_word(logic op, logic [HZ_W-1:0] hz, logic [AIR_W-1:0] air,
                            logic [TIME_W-1:0] now, logic sos,
                            logic signed [RSSI_W-1:0] rssi);
      logic [BAND_W-1:0] band;
      longint unsigned   budget, used_all, used_sos;
      int unsigned       slot;
      decision_e         verdict;
      band = subband_of(hz);

      // record: append, overwrite oldest once the ring is full
      if (op == OP_RECORD) begin
        slot = (head + fill) % RING_DEPTH;
        ent_t[slot]    = now;
        ent_air[slot]  = air;
        ent_band[slot] = band;
        ent_sos[slot]  = sos;
        if (fill < RING_DEPTH) fill++;
        else head = (head + 1) % RING_DEPTH;
        return;
      end

      if (band == BAND_NONE) begin
        expected_decisions.push_back(DEC_ERROR);
        return;
      end

      // in-window airtime of this band, all entries and SOS-marked ones
      budget = 64'(SUBBAND_PM[band]) * 64'(win_ms) / 64'd1000;
      used_all = 0;
      used_sos = 0;
      for (int unsigned i = 0; i < fill; i++) begin
        slot = (head + i) % RING_DEPTH;
        if (ent_band[slot] == band && (now - ent_t[slot]) <= win_ms) begin
          used_all += 64'(ent_air[slot]);
          if (ent_sos[slot]) used_sos += 64'(ent_air[slot]);
        end
      end

      if (used_all + 64'(air) <= budget) verdict = DEC_ALLOW;
      else if (sos && used_sos + 64'(air) <= 64'(sos_ms)) verdict = DEC_SOS;
      else verdict = DEC_BLOCK;
      // LBT only matters once the duty check has passed
      if (verdict != DEC_BLOCK && rssi >= busy_dbm) verdict = DEC_BUSY;
      expected_decisions.push_back(verdict);
    endfunction

    function void check_decision(logic [2:0] got);
      decision_e want;
      if (expected_decisions.size() == 0) begin
        $error("decision: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = expected_decisions.pop_front();
      if (got !== want) begin
        $error("decision: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_decisions.size();
    endfunction
  endclass

endpackage

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dclg_pkg::*;
  import gate_tb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned PHASE_WORDS    = 225;

  logic                     clk = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     op_i;
  logic [HZ_W-1:0]          carrier_hz_i;
  logic [AIR_W-1:0]         air_ms_i;
  logic [TIME_W-1:0]        time_now_ms_i;
  logic                     sos_flag_i;
  logic signed [RSSI_W-1:0] channel_rssi_dbm_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [2:0]               decision_o;

  gate_scoreboard sb = new();

  logic [TIME_W-1:0] clock_ms;
  int unsigned       idle_cycles = 0;
  int unsigned       rx_mode = 0;
  int unsigned       rx_left = 0;

  duty_cycle_lbt_gate_core uut (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .carrier_hz_i       (carrier_hz_i),
    .air_ms_i           (air_ms_i),
    .time_now_ms_i      (time_now_ms_i),
    .sos_flag_i         (sos_flag_i),
    .channel_rssi_dbm_i (channel_rssi_dbm_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .decision_o         (decision_o)
  );

  always #5 clk = ~clk;

  // Receiver: stretches of always-ready, coin-flip and mostly-stalled
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(1, 60);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      2: out_ready_i = 1'($urandom_range(0, 1));
      3: out_ready_i = ($urandom_range(0, 7) == 0);
      default: out_ready_i = 1'b1;
    endcase
  end

  // Decision checker
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_decision(decision_o);
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request word and hold it until accepted; valid stays high
  task automatic send_word(logic op, int unsigned hz, int unsigned air,
                           logic [TIME_W-1:0] now, logic sos, int rssi);
    @(negedge clk);
    in_valid_i         = 1'b1;
    op_i               = op;
    carrier_hz_i       = HZ_W'(hz);
    air_ms_i           = AIR_W'(air);
    time_now_ms_i      = now;
    sos_flag_i         = sos;
    channel_rssi_dbm_i = RSSI_W'(rssi);
    do @(posedge clk); while (!in_ready_o);
    sb.note_word(op_i, carrier_hz_i, air_ms_i, time_now_ms_i, sos_flag_i,
                 channel_rssi_dbm_i);
  endtask

  task automatic idle_sender(int unsigned n);
    @(negedge clk);
    in_valid_i = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop sending until every decision is back, then let the block settle
  task automatic drain();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, data);
  endtask

  // threshold in the low bits, junk above it
  function automatic logic [CFG_W-1:0] busy_word(int thr);
    return {13'($urandom), RSSI_W'(thr)};
  endfunction

  task automatic write_all(int unsigned win, int unsigned sos, int thr);
    cfg_write(CFG_WINDOW, CFG_W'(win));
    cfg_write(CFG_SOS, CFG_W'(sos));
    cfg_write(CFG_BUSY, busy_word(thr));
  endtask

  // Edges of every sub-band, gaps, SOS, busy, window edge and wrap
  task automatic directed_words();
    logic [TIME_W-1:0] t0;
    t0 = 32'h0000_1000;
    send_word(OP_EVAL, 0, 0, t0, 1'b0, 50);
    send_word(OP_EVAL, 30'h3FFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1, -1);
    send_word(OP_EVAL, 862999999, 5, t0, 1'b0, -200);
    send_word(OP_EVAL, 863000000, 0, t0, 1'b0, -200);
    send_word(OP_EVAL, 867999999, 36000, t0, 1'b0, -81);
    send_word(OP_EVAL, 868000000, 36001, t0, 1'b0, -200);
    send_word(OP_EVAL, 868600000, 1, t0, 1'b0, -200);
    send_word(OP_EVAL, 868700000, 3601, t0, 1'b1, -200);
    send_word(OP_EVAL, 869199999, 10, t0, 1'b0, -80);
    send_word(OP_EVAL, 869399999, 1, t0, 1'b0, -200);
    send_word(OP_EVAL, 869400000, 360000, t0, 1'b0, -200);
    send_word(OP_EVAL, 869649999, 360001, t0, 1'b1, 50);
    send_word(OP_EVAL, 869699999, 1, t0, 1'b0, -200);
    send_word(OP_EVAL, 869700000, 1, t0, 1'b0, -200);
    send_word(OP_EVAL, 869999999, 1, t0, 1'b0, 50);
    send_word(OP_EVAL, 870000000, 1, t0, 1'b0, -200);
    // band 3 history: SOS and plain entries
    send_word(OP_RECORD, 868700000, 3000, t0, 1'b1, 0);
    send_word(OP_RECORD, 869000000, 500, t0, 1'b0, 0);
    send_word(OP_EVAL, 869000000, 101, t0, 1'b1, -200);
    send_word(OP_EVAL, 869000000, 101, t0, 1'b0, 50);
    send_word(OP_EVAL, 868800000, 100, t0, 1'b0, -79);
    // out-of-band record never counts; future stamp falls outside the window
    send_word(OP_RECORD, 0, 24'hFF_FFFF, t0, 1'b1, 0);
    send_word(OP_RECORD, 863500000, 36000, t0 + 32'd1000, 1'b0, 0);
    send_word(OP_EVAL, 863500000, 1, t0, 1'b0, -200);
    // entry exactly one window back, stamp wrapped below zero
    send_word(OP_RECORD, 869500000, 24'hFF_FFFF, t0 - 32'd3600000, 1'b1, 0);
    send_word(OP_EVAL, 869500000, 0, t0, 1'b0, -200);
    send_word(OP_EVAL, 869500000, 0, t0 + 32'd1, 1'b0, -200);
    clock_ms = t0 + 32'd2;
  endtask

  // Mostly in-band words sized against the current budgets, some noise
  task automatic run_phase(int unsigned n_words);
    int unsigned burst, sel, band, budget, hz, air;
    logic        op, sos;
    logic [TIME_W-1:0] t;
    int          rssi;
    burst = $urandom_range(1, 20);
    for (int unsigned k = 0; k < n_words; k++) begin
      if (burst == 0) begin
        idle_sender($urandom_range(1, 12));
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      end
      burst--;
      if ($urandom_range(0, 19) == 0) clock_ms += $urandom_range(0, 2 * sb.win_ms + 10);
      else clock_ms += $urandom_range(0, sb.win_ms / 16 + 1);
      t = clock_ms;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        // raw noise over the full field widths, RSSI drawn from -200 to 50
        op   = 1'($urandom);
        hz   = $urandom;
        air  = $urandom;
        t    = $urandom;
        sos  = 1'($urandom);
        rssi = int'($urandom_range(0, 250)) - 200;
      end else begin
        band = $urandom_range(1, 5);
        hz = SUBBAND_LO[band-1] +
             $urandom_range(0, SUBBAND_HI[band-1] - SUBBAND_LO[band-1] - 1);
        if (sel < 15) begin
          case ($urandom_range(0, 2))
            0: hz = 868600000 + $urandom_range(0, 99999);
            1: hz = 869200000 + $urandom_range(0, 199999);
            default: hz = 869650000 + $urandom_range(0, 49999);
          endcase
        end
        budget = SUBBAND_PM[band] * sb.win_ms / 1000;
        op  = ($urandom_range(0, 99) < 45) ? OP_RECORD : OP_EVAL;
        sos = ($urandom_range(0, 4) < 2);
        if (op == OP_RECORD) begin
          air = $urandom_range(0, budget / 3 + 2);
          if ($urandom_range(0, 19) == 0) t = clock_ms + $urandom_range(1, 1000);
        end else if ($urandom_range(0, 4) == 0) begin
          air = $urandom_range(0, 2 * budget + 4);
        end else begin
          air = $urandom_range(0, budget / 2 + 4);
        end
        if ($urandom_range(0, 2) == 0) rssi = int'($urandom_range(0, 250)) - 200;
        else rssi = -200 + int'($urandom_range(0, 30));
      end
      send_word(op, hz, air, t, sos, rssi);
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_WINDOW;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    op_i               = OP_EVAL;
    carrier_hz_i       = '0;
    air_ms_i           = '0;
    time_now_ms_i      = '0;
    sos_flag_i         = 1'b0;
    channel_rssi_dbm_i = '0;
    clock_ms           = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // reset defaults first
    directed_words();
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_all(4194303, 0, -200);
        1: begin
          write_all(1, 4194303, 50);
          cfg_write(CFG_IDX_SPARE, 22'h3F_FFFF);
        end
        2: write_all(10000, 200, -80);
        3: write_all($urandom_range(1, 4194303), 22'($urandom),
                     int'($urandom_range(0, 250)) - 200);
        4: write_all(100000, 5000, -100);
        default: write_all(3600000, 36000, -80);
      endcase
      run_phase(PHASE_WORDS);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
